/* rtl/signed_counted_multiset_table_defines.svh */
// assertion macros for the multiset table rtl
`ifndef SIGNED_COUNTED_MULTISET_TABLE_DEFINES_SVH
`define SIGNED_COUNTED_MULTISET_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sct_pkg.sv */
// types and constants of the signed counted multiset table
`timescale 1ns / 1ps

package sct_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = 32;
    localparam int ID_W    = 32;
    localparam int ENT_W   = 5;
    localparam int N_W     = $clog2(DEPTH + 1);

    localparam logic signed [ID_W-1:0] ID_MIN = {1'b1, {(ID_W - 1){1'b0}}};

    // command codes
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_REM = 2'd1;
    localparam logic [1:0] CMD_CMP = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [CNT_W-1:0]       cnt;
    } t_entry;

    // what every cell updates in the execute cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INC,
        OP_DEC,
        OP_DROP,
        OP_INS
    } t_op;

    // key broadcast to all cells
    typedef struct packed {
        logic                   bank;
        logic signed [ID_W-1:0] key;
        logic signed [ID_W-1:0] neg;
    } t_probe;

    typedef struct packed {
        logic en;
        t_op  op;
        logic use_neg;
    } t_act;

    // per-cell compare results
    typedef struct packed {
        logic eq_key;
        logic eq_neg;
        logic lt_key;
        logic lt_neg;
        logic max_key;
        logic one_key;
        logic one_neg;
        logic same;
    } t_flags;

endpackage

/* rtl/sct_if.sv */
// command and response channel interfaces
`timescale 1ns / 1ps

interface sct_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           command;
    logic                                 bank;
    logic signed [sct_pkg::ID_W-1:0]      id;

    modport source (output valid, command, bank, id, input ready);
    modport sink (input valid, command, bank, id, output ready);
endinterface

interface sct_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic                                 equal;
    logic [sct_pkg::ENT_W-1:0]            entries_now;
    logic [1:0]                           status;

    modport source (output valid, found, equal, entries_now, status, input ready);
    modport sink (input valid, found, equal, entries_now, status, output ready);
endinterface

/* rtl/sct_cell.sv */
// one table slot holding the entry of each bank at this sorted position
`timescale 1ns / 1ps

module sct_cell (
    input  logic             i_clk,
    input  sct_pkg::t_probe  i_probe,
    input  sct_pkg::t_act    i_act,
    input  logic             i_valid,
    input  sct_pkg::t_flags  i_left_flags,
    input  sct_pkg::t_entry  i_left,
    input  sct_pkg::t_entry  i_right,
    output sct_pkg::t_entry  o_entry,
    output sct_pkg::t_flags  o_flags
);
    import sct_pkg::*;

    t_entry r_ent [2];
    t_entry w_cur;
    t_entry w_new;
    logic   w_eq;
    logic   w_lt;
    logic   w_left_lt;
    logic   w_at_max;
    logic   w_is_one;

    assign w_cur   = r_ent[i_probe.bank];
    assign o_entry = w_cur;

    // compare the selected bank entry against key and negated key
    assign w_at_max = &w_cur.cnt;
    assign w_is_one = (w_cur.cnt <= CNT_W'(1));

    always_comb begin
        o_flags         = '0;
        o_flags.eq_key  = i_valid && (w_cur.id == i_probe.key);
        o_flags.eq_neg  = i_valid && (w_cur.id == i_probe.neg);
        o_flags.lt_key  = i_valid && ($signed(w_cur.id) < $signed(i_probe.key));
        o_flags.lt_neg  = i_valid && ($signed(w_cur.id) < $signed(i_probe.neg));
        o_flags.max_key = o_flags.eq_key && w_at_max;
        o_flags.one_key = o_flags.eq_key && w_is_one;
        o_flags.one_neg = o_flags.eq_neg && w_is_one;
        o_flags.same    = (r_ent[0] == r_ent[1]);
    end

    // pick the key the update acts on
    assign w_eq      = i_act.use_neg ? o_flags.eq_neg : o_flags.eq_key;
    assign w_lt      = i_act.use_neg ? o_flags.lt_neg : o_flags.lt_key;
    assign w_left_lt = i_act.use_neg ? i_left_flags.lt_neg : i_left_flags.lt_key;

    assign w_new.id  = i_probe.key;
    assign w_new.cnt = CNT_W'(1);

    // count update or shift toward a neighbor
    always_ff @(posedge i_clk) begin
        if (i_act.en) begin
            case (i_act.op)
                OP_INC: begin
                    if (w_eq) begin
                        r_ent[i_probe.bank].cnt <= w_cur.cnt + CNT_W'(1);
                    end
                end
                OP_DEC: begin
                    if (w_eq) begin
                        r_ent[i_probe.bank].cnt <= w_cur.cnt - CNT_W'(1);
                    end
                end
                OP_DROP: begin
                    if (!w_lt) begin
                        r_ent[i_probe.bank] <= i_right;
                    end
                end
                OP_INS: begin
                    if (!w_lt) begin
                        r_ent[i_probe.bank] <= w_left_lt ? w_new : i_left;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/signed_counted_multiset_table.sv */
// Two banks of sorted (signed id, count) entries, up to sct_pkg::DEPTH per bank,
// held in a row of cells where cell k keeps position k of both banks. Every
// command is captured and its id negated in the idle state; in the execute
// state all cells compare their entry against the id and its negation and
// then increment, decrement, or shift one place left or right together. The
// result sits in an output register; the next command is taken in the cycle
// after the update, even while that result still waits, and the update of a
// command waits only when the previous result has not been taken. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps
`include "signed_counted_multiset_table_defines.svh"

module signed_counted_multiset_table (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sct_cmd_if.sink   i_cmd,
    sct_rsp_if.source o_rsp
);
    import sct_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    localparam t_flags EDGE_FLAGS = '{lt_key: 1'b1, lt_neg: 1'b1, default: 1'b0};

    t_state                  r_state;
    logic [1:0]              r_cmd;
    logic                    r_bank;
    logic signed [ID_W-1:0]  r_key;
    logic signed [ID_W-1:0]  r_neg;
    logic [N_W-1:0]          r_n [2];

    logic                    r_out_valid;
    logic                    r_found;
    logic                    r_equal;
    logic [ENT_W-1:0]        r_entries;
    logic [1:0]              r_status;

    logic                    n_found;
    logic                    n_equal;
    logic [1:0]              n_status;
    logic [N_W-1:0]          n_n;
    t_op                     w_op;
    logic                    w_use_neg;
    logic                    w_load;
    logic [N_W-1:0]          w_n_sel;

    t_probe                  w_probe;
    t_act                    w_act;
    t_entry                  w_ent   [DEPTH];
    t_flags                  w_fl    [DEPTH];
    logic [DEPTH-1:0]        w_valid;
    logic [DEPTH-1:0]        w_eq_key;
    logic [DEPTH-1:0]        w_eq_neg;
    logic [DEPTH-1:0]        w_max_key;
    logic [DEPTH-1:0]        w_one_key;
    logic [DEPTH-1:0]        w_one_neg;
    logic [DEPTH-1:0]        w_same_ok;

    assign w_n_sel = r_n[r_bank];
    assign w_load  = !r_out_valid || o_rsp.ready;

    assign w_probe.bank = r_bank;
    assign w_probe.key  = r_key;
    assign w_probe.neg  = r_neg;

    assign w_act.en      = (r_state == S_EXEC) && w_load;
    assign w_act.op      = w_op;
    assign w_act.use_neg = w_use_neg;

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_flags w_left_fl;
        t_entry w_left_ent;
        t_entry w_right_ent;

        if (g == 0) begin : g_first
            assign w_left_fl  = EDGE_FLAGS;
            assign w_left_ent = '0;
        end else begin : g_mid
            assign w_left_fl  = w_fl[g-1];
            assign w_left_ent = w_ent[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_ent = '0;
        end else begin : g_inner
            assign w_right_ent = w_ent[g+1];
        end

        assign w_valid[g]   = (N_W'(g) < w_n_sel);
        assign w_eq_key[g]  = w_fl[g].eq_key;
        assign w_eq_neg[g]  = w_fl[g].eq_neg;
        assign w_max_key[g] = w_fl[g].max_key;
        assign w_one_key[g] = w_fl[g].one_key;
        assign w_one_neg[g] = w_fl[g].one_neg;
        assign w_same_ok[g] = !(N_W'(g) < r_n[0]) || w_fl[g].same;

        sct_cell u_cell (
            .i_clk        (i_clk),
            .i_probe      (w_probe),
            .i_act        (w_act),
            .i_valid      (w_valid[g]),
            .i_left_flags (w_left_fl),
            .i_left       (w_left_ent),
            .i_right      (w_right_ent),
            .o_entry      (w_ent[g]),
            .o_flags      (w_fl[g])
        );
    end

    // decide the common action from the gathered cell flags
    always_comb begin
        w_op      = OP_NONE;
        w_use_neg = 1'b0;
        n_found   = 1'b0;
        n_equal   = 1'b0;
        n_status  = ST_OK;
        n_n       = w_n_sel;
        case (r_cmd)
            CMD_ADD: begin
                if ((r_key != '0) && (r_key != ID_MIN) && (|w_eq_neg)) begin
                    w_use_neg = 1'b1;
                    n_found   = 1'b1;
                    if (|w_one_neg) begin
                        w_op = OP_DROP;
                        n_n  = w_n_sel - N_W'(1);
                    end else begin
                        w_op = OP_DEC;
                    end
                end else if (|w_eq_key) begin
                    if (|w_max_key) begin
                        n_status = ST_SAT;
                    end else begin
                        w_op = OP_INC;
                    end
                end else if (w_n_sel == N_W'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    w_op = OP_INS;
                    n_n  = w_n_sel + N_W'(1);
                end
            end
            CMD_REM: begin
                if (|w_eq_key) begin
                    n_found = 1'b1;
                    if (|w_one_key) begin
                        w_op = OP_DROP;
                        n_n  = w_n_sel - N_W'(1);
                    end else begin
                        w_op = OP_DEC;
                    end
                end
            end
            CMD_CMP: begin
                n_equal = (r_n[0] == r_n[1]) && (&w_same_ok);
            end
            default: begin
            end
        endcase
    end

    // sequencer, entry counts and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_n[0]      <= '0;
            r_n[1]      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.command;
                        r_bank  <= i_cmd.bank;
                        r_key   <= i_cmd.id;
                        r_neg   <= -i_cmd.id;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // a waiting result is replaced in the cycle it is taken
                    if (w_load) begin
                        r_n[r_bank] <= n_n;
                        r_out_valid <= 1'b1;
                        r_found     <= n_found;
                        r_equal     <= n_equal;
                        r_entries   <= ENT_W'(n_n);
                        r_status    <= n_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_found;
    assign o_rsp.equal       = r_equal;
    assign o_rsp.entries_now = r_entries;
    assign o_rsp.status      = r_status;

    // checks
    `SCT_ASSERT_NOW(a_full_only_when_full, o_rsp.valid && (o_rsp.status == ST_FULL), o_rsp.entries_now == ENT_W'(DEPTH), "full status on a bank that is not full")
    `SCT_ASSERT_NOW(a_found_equal_excl, o_rsp.valid, !(o_rsp.found && o_rsp.equal), "found and equal on the same word")
    `SCT_ASSERT_NEXT(a_accept_starts_exec, i_cmd.valid && i_cmd.ready, (r_state == S_EXEC) && !i_cmd.ready, "accepted word did not enter execute")

endmodule
